// ===== hdl/stbs_pkg.sv =====
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int COUNT_W = 11;
    localparam int MAX_COUNT = (1 << COUNT_W) - 1;
    localparam int VALUE_W = 32;
    localparam int POS_W = 11;
    localparam int MODE_W = 3;
    localparam int BOUND_W = 12;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [MODE_W-1:0] MODE_EXACT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST_GE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LAST_LE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIRST_EQ = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAST_EQ = 3'd4;

    typedef struct packed {
        logic write;
        logic start;
        logic read;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic over;
    } stat_t;

endpackage

// ===== hdl/stbs_ctrl.sv =====
`timescale 1ns / 1ps

module stbs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_op,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  stbs_pkg::stat_t  stat,
    output stbs_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == stbs_pkg::OP_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (stat.over) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.step   = 1'b1;
                state_next = ST_READ;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/stbs_dp.sv =====
`timescale 1ns / 1ps

module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  stbs_pkg::cmd_t                      cmd,
    output stbs_pkg::stat_t                     stat,
    input  logic                                cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic [stbs_pkg::MODE_W-1:0]         search_mode,
    input  logic [stbs_pkg::POS_W-1:0]          write_position,
    input  logic signed [stbs_pkg::VALUE_W-1:0] value,
    output logic                                found,
    output logic [stbs_pkg::POS_W-1:0]          position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH + 1);
    localparam int CAP = (TABLE_DEPTH > stbs_pkg::MAX_COUNT) ? stbs_pkg::MAX_COUNT : TABLE_DEPTH;
    localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);
    localparam int BW = stbs_pkg::BOUND_W;
    localparam int PW = stbs_pkg::POS_W;

    logic signed [stbs_pkg::VALUE_W-1:0] mem [0:TABLE_DEPTH];

    logic [stbs_pkg::COUNT_W-1:0]        count_reg;
    logic signed [stbs_pkg::VALUE_W-1:0] key_reg;
    logic signed [stbs_pkg::VALUE_W-1:0] rd_data_reg;
    logic [stbs_pkg::MODE_W-1:0]         mode_reg;
    logic [BW-1:0]                       lo_reg, lo_next;
    logic [BW-1:0]                       hi_reg, hi_next;
    logic [PW-1:0]                       mid_reg;
    logic [PW-1:0]                       hit_reg, hit_next;
    logic                                exact_reg, exact_next;
    logic                                found_reg;
    logic [PW-1:0]                       position_reg;

    logic [31:0]     wr_wide;
    logic [ADDR_W-1:0] wr_addr;
    logic            wr_in_range;
    logic [BW:0]     bound_sum;
    logic [BW-1:0]   half;
    logic [PW-1:0]   mid_calc;
    logic [31:0]     rd_wide;
    logic [ADDR_W-1:0] rd_addr;
    logic [BW-1:0]   count_cap;
    logic [BW-1:0]   mid_minus;
    logic [BW-1:0]   mid_plus;
    logic            e_eq, e_gt;

    assign wr_wide     = 32'(write_position);
    assign wr_addr     = wr_wide[ADDR_W-1:0];
    assign wr_in_range = (write_position != '0) && (wr_wide <= DEPTH_U);

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign half      = bound_sum[BW:1];
    assign mid_calc  = half[PW-1:0];
    assign rd_wide   = 32'(mid_calc);
    assign rd_addr   = rd_wide[ADDR_W-1:0];

    assign count_cap = (32'(count_reg) > DEPTH_U) ? BW'(CAP) : {1'b0, count_reg};
    assign mid_minus = {1'b0, mid_reg} - BW'(1);
    assign mid_plus  = {1'b0, mid_reg} + BW'(1);

    assign e_eq = (rd_data_reg == key_reg);
    assign e_gt = (rd_data_reg > key_reg);

    assign stat.over = (lo_reg > hi_reg) || exact_reg || (mode_reg > stbs_pkg::MODE_LAST_EQ);

    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        hit_next   = hit_reg;
        exact_next = exact_reg;
        unique case (mode_reg)
            stbs_pkg::MODE_EXACT: begin
                if (e_eq) begin
                    hit_next   = mid_reg;
                    exact_next = 1'b1;
                end else if (e_gt) begin
                    hi_next = mid_minus;
                end else begin
                    lo_next = mid_plus;
                end
            end
            stbs_pkg::MODE_FIRST_GE: begin
                if (e_eq || e_gt) begin
                    hit_next = mid_reg;
                    hi_next  = mid_minus;
                end else begin
                    lo_next = mid_plus;
                end
            end
            stbs_pkg::MODE_LAST_LE: begin
                if (!e_gt) begin
                    hit_next = mid_reg;
                    lo_next  = mid_plus;
                end else begin
                    hi_next = mid_minus;
                end
            end
            stbs_pkg::MODE_FIRST_EQ: begin
                if (e_eq) begin
                    hit_next = mid_reg;
                    hi_next  = mid_minus;
                end else if (e_gt) begin
                    hi_next = mid_minus;
                end else begin
                    lo_next = mid_plus;
                end
            end
            stbs_pkg::MODE_LAST_EQ: begin
                if (e_eq) begin
                    hit_next = mid_reg;
                    lo_next  = mid_plus;
                end else if (e_gt) begin
                    hi_next = mid_minus;
                end else begin
                    lo_next = mid_plus;
                end
            end
            default: begin
                hit_next = hit_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write && wr_in_range) begin
            mem[wr_addr] <= value;
        end
        if (cmd.read) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg   <= value;
            mode_reg  <= search_mode;
            lo_reg    <= BW'(1);
            hi_reg    <= count_cap;
            hit_reg   <= '0;
            exact_reg <= 1'b0;
        end else if (cmd.step) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            hit_reg   <= hit_next;
            exact_reg <= exact_next;
        end
        if (cmd.read) begin
            mid_reg <= mid_calc;
        end
        if (cmd.emit) begin
            found_reg    <= (hit_reg != '0);
            position_reg <= hit_reg;
        end
    end

    assign found    = found_reg;
    assign position = position_reg;

endmodule

// ===== hdl/sorted_table_binary_search_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Content
// s_*       in   s_tvalid / s_tready  tdata: write_position, value; tuser: op, search_mode
// m_*       out  m_tvalid / m_tready  tdata: found, position
// cfg_*     in   cfg_wr_en            cfg_wr_data: element_count
//
// A write transfer leaves s_tready high. A search runs bisection steps (table read, then
// compare) until the bounds cross or an exact-mode match is found, holding s_tready low until
// its result is emitted; the registered table read sets the step time.
// Reset (aresetn low, synchronous) clears control and element_count; table contents stay undefined.
// A finished result holds in the output register while new transfers are taken;
// a search that ends while it is still held waits for the slot.

module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0]   s_tdata,  // write_position, value, zero pad
    input  logic [stbs_pkg::S_TUSER_W-1:0]   s_tuser,  // op, search_mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]   m_tdata,  // found, position, zero pad
    input  logic                             cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]     cfg_wr_data
);

    localparam int PW = stbs_pkg::POS_W;
    localparam int VW = stbs_pkg::VALUE_W;
    localparam int MW = stbs_pkg::MODE_W;

    stbs_pkg::cmd_t  cmd;
    stbs_pkg::stat_t stat;
    logic            found;
    logic [PW-1:0]   position;

    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .search_mode    (s_tuser[MW:1]),
        .write_position (s_tdata[PW-1:0]),
        .value          (s_tdata[PW+VW-1:PW]),
        .found          (found),
        .position       (position)
    );

    assign m_tdata = {{(stbs_pkg::M_TDATA_W - PW - 1){1'b0}}, position, found};

endmodule
